// ----- hw/rtl/bml_pkg.sv -----
// Shared types, event codes and character constants for the bracket markup lexer.
`default_nettype none

package bml_pkg;

   // Depth of the queue between the classifier and the event sequencer
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Most events that one source byte can cause
   localparam int MAX_EVENTS = 3;

   // Event codes
   localparam logic [2:0] EV_TEXT    = 3'd0;
   localparam logic [2:0] EV_CMDCHAR = 3'd1;
   localparam logic [2:0] EV_OPEN    = 3'd2;
   localparam logic [2:0] EV_TERM    = 3'd3;
   localparam logic [2:0] EV_CLOSE   = 3'd4;
   localparam logic [2:0] EV_BAD     = 3'd5;
   localparam logic [2:0] EV_STRAY   = 3'd6;
   localparam logic [2:0] EV_END     = 3'd7;

   // End status codes
   localparam logic [1:0] END_OK       = 2'd0;
   localparam logic [1:0] END_OPEN_CMD = 2'd1;
   localparam logic [1:0] END_DANGLING = 2'd2;
   localparam logic [1:0] END_UNMATCH  = 2'd3;

   // Characters with a meaning of their own
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [7:0] CHAR_DASH     = 8'h2D;

   // One input item
   typedef struct packed {
      logic [7:0] byte_in;
      logic       is_final;
   } req_type;

   // One result item
   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  char_out;
      logic [31:0] byte_offset;
      logic [1:0]  end_status;
      logic        final_result;
   } rsp_type;

   // One event inside a bundle
   typedef struct packed {
      logic [2:0] code;
      logic [7:0] char_val;
      logic [1:0] status;
   } evt_type;

   // All events of one source byte, sharing its offset
   typedef struct packed {
      logic [1:0]                count;
      evt_type [MAX_EVENTS-1:0]  evts;
      logic [31:0]               offset;
   } bundle_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bracket_markup_lexer.sv -----
// Top level of the bracket markup lexer: classifier, bundle queue, sequencer.
//
//   channel   direction  handshake             payload
//   req_      in         push / full           req_data  (byte_in, is_final)
//   rsp_      out        pop / empty           rsp_data  (event_res, char_out,
//                                                         byte_offset, end_status,
//                                                         final_result)
//
// One source byte is accepted per cycle while the bundle queue has room.
// The first result of a byte reaches rsp_data after its bundle is written into the
// queue and then loaded into the sequencer. A byte causes zero to three result
// items; the sequencer hands out one item per cycle while pop is high.
// Up to QUEUE_DEPTH bundles wait between the two sides, so either side can
// stall without stopping the other. Synchronous reset clears mode, offset,
// queue and sequencer; no clearing pass follows reset.
`default_nettype none

module bracket_markup_lexer #(
   parameter int QUEUE_DEPTH = bml_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output      logic              full,
   input  wire bml_pkg::req_type  req_data,
   output      logic              empty,
   input  wire logic              pop,
   output      bml_pkg::rsp_type  rsp_data
);

   bml_pkg::bundle_type front_bundle, q_head;
   logic                front_valid, q_full, q_empty, q_pop;
   logic                accept;

   assign accept = push && !q_full;
   assign full   = q_full;

   bml_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_data),
      .bundle       (front_bundle),
      .bundle_valid (front_valid)
   );

   bml_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_bundle),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   bml_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp       (rsp_data),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   // An end event always closes the results of its byte
   a_end_is_final: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.event_res == bml_pkg::EV_END) |-> rsp_data.final_result)
      else $error("end event not marked final");

   // Status is reported on end events only
   a_status_on_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.event_res != bml_pkg::EV_END) |->
      (rsp_data.end_status == bml_pkg::END_OK))
      else $error("end status on a non-end event");

   // Only character events carry a character
   a_char_only_on_char: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.event_res != bml_pkg::EV_TEXT &&
       rsp_data.event_res != bml_pkg::EV_CMDCHAR && rsp_data.event_res != bml_pkg::EV_BAD)
      |-> (rsp_data.char_out == 8'd0))
      else $error("character on a non-character event");

   // Reset leaves both sides empty
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("block not empty after reset");

endmodule

`default_nettype wire

// ----- hw/rtl/bml_front.sv -----
// Classifier: tracks lexer mode and offset, turns each byte into an event bundle.
`default_nettype none

module bml_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire bml_pkg::req_type      req,
   output      bml_pkg::bundle_type   bundle,
   output      logic                  bundle_valid
);

   // Lexer modes
   localparam logic [1:0] MODE_TEXT    = 2'd0;
   localparam logic [1:0] MODE_LEFT    = 2'd1;
   localparam logic [1:0] MODE_RIGHT   = 2'd2;
   localparam logic [1:0] MODE_COMMAND = 2'd3;

   logic [1:0]  mode_ff, mode_in;
   logic [31:0] offset_ff, offset_in;

   bml_pkg::evt_type [bml_pkg::MAX_EVENTS-1:0] evts;
   logic [1:0] n;
   logic [1:0] status;
   logic [7:0] c;

   function automatic logic is_blank(input logic [7:0] ch);
      return (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
   endfunction

   function automatic logic is_name(input logic [7:0] ch);
      return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
             (ch >= 8'h61 && ch <= 8'h7A) || ch == bml_pkg::CHAR_DOT ||
             ch == bml_pkg::CHAR_DASH;
   endfunction

   function automatic bml_pkg::evt_type mk_evt(input logic [2:0] code,
                                              input logic [7:0] ch,
                                              input logic [1:0] st);
      bml_pkg::evt_type e;
      e.code     = code;
      e.char_val = ch;
      e.status   = st;
      return e;
   endfunction

   // Mode transition and event list for the byte at the input
   always_comb begin
      evts    = '0;
      n       = 2'd0;
      status  = bml_pkg::END_OK;
      mode_in = mode_ff;
      c       = req.byte_in;
      unique case (mode_ff)
         MODE_TEXT: begin
            priority if (c == bml_pkg::CHAR_LBRACKET) begin
               mode_in = MODE_LEFT;
            end else if (c == bml_pkg::CHAR_RBRACKET) begin
               mode_in = MODE_RIGHT;
            end else begin
               evts[n] = mk_evt(bml_pkg::EV_TEXT, c, bml_pkg::END_OK);
               n       = n + 2'd1;
            end
         end
         MODE_LEFT: begin
            priority if (c == bml_pkg::CHAR_LBRACKET) begin
               evts[n] = mk_evt(bml_pkg::EV_TEXT, bml_pkg::CHAR_LBRACKET,
                                bml_pkg::END_OK);
               n       = n + 2'd1;
               mode_in = MODE_TEXT;
            end else if (c == bml_pkg::CHAR_RBRACKET) begin
               evts[n] = mk_evt(bml_pkg::EV_TERM, 8'd0, bml_pkg::END_OK);
               n       = n + 2'd1;
               mode_in = MODE_TEXT;
            end else begin
               evts[n] = mk_evt(bml_pkg::EV_OPEN, 8'd0, bml_pkg::END_OK);
               n       = n + 2'd1;
               if (!is_blank(c)) begin
                  evts[n] = mk_evt(is_name(c) ? bml_pkg::EV_CMDCHAR : bml_pkg::EV_BAD,
                                   c, bml_pkg::END_OK);
                  n       = n + 2'd1;
               end
               mode_in = MODE_COMMAND;
            end
         end
         MODE_RIGHT: begin
            // "]]" is a literal close bracket; anything else is a stray ']'
            evts[n] = mk_evt(bml_pkg::EV_TEXT, c, bml_pkg::END_OK);
            n       = n + 2'd1;
            if (c != bml_pkg::CHAR_RBRACKET) begin
               evts[n] = mk_evt(bml_pkg::EV_STRAY, 8'd0, bml_pkg::END_OK);
               n       = n + 2'd1;
            end
            mode_in = MODE_TEXT;
         end
         MODE_COMMAND: begin
            priority if (c == bml_pkg::CHAR_RBRACKET) begin
               evts[n] = mk_evt(bml_pkg::EV_CLOSE, 8'd0, bml_pkg::END_OK);
               n       = n + 2'd1;
               mode_in = MODE_TEXT;
            end else if (!is_blank(c)) begin
               evts[n] = mk_evt(is_name(c) ? bml_pkg::EV_CMDCHAR : bml_pkg::EV_BAD,
                                c, bml_pkg::END_OK);
               n       = n + 2'd1;
            end else begin
               n = n;
            end
         end
         default: begin
            mode_in = MODE_TEXT;
         end
      endcase

      // End of source: status from the mode reached, then back to text
      if (req.is_final) begin
         unique case (mode_in)
            MODE_COMMAND: status = bml_pkg::END_OPEN_CMD;
            MODE_LEFT:    status = bml_pkg::END_DANGLING;
            MODE_RIGHT:   status = bml_pkg::END_UNMATCH;
            default:      status = bml_pkg::END_OK;
         endcase
         evts[n] = mk_evt(bml_pkg::EV_END, 8'd0, status);
         n       = n + 2'd1;
         mode_in = MODE_TEXT;
      end
   end

   // Offset: saturating count, cleared after the final byte
   always_comb begin
      if (req.is_final) begin
         offset_in = 32'd0;
      end else if (offset_ff != 32'hFFFF_FFFF) begin
         offset_in = offset_ff + 32'd1;
      end else begin
         offset_in = offset_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TEXT;
         offset_ff <= 32'd0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
      end
   end

   // Quiet bytes cause no bundle
   assign bundle.count  = n;
   assign bundle.evts   = evts;
   assign bundle.offset = offset_ff;
   assign bundle_valid  = accept && (n != 2'd0);

endmodule

`default_nettype wire

// ----- hw/rtl/bml_queue.sv -----
// Short queue of event bundles between the classifier and the sequencer.
`default_nettype none

module bml_queue #(
   parameter int DEPTH = bml_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire bml_pkg::bundle_type   push_data,
   output      logic                  full,
   input  wire logic                  pop,
   output      bml_pkg::bundle_type   head,
   output      logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   bml_pkg::bundle_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bml_back.sv -----
// Sequencer: holds one bundle and hands out its events one item per cycle while rsp_pop is high.
`default_nettype none

module bml_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bml_pkg::bundle_type   head,
   input  wire logic                  q_empty,
   output      logic                  q_pop,
   output      bml_pkg::rsp_type      rsp,
   output      logic                  rsp_empty,
   input  wire logic                  rsp_pop
);

   bml_pkg::bundle_type cur_ff, cur_in;
   logic                valid_ff, valid_in;
   logic [1:0]          idx_ff, idx_in;
   logic                last, take, load;
   bml_pkg::evt_type    evt;

   assign last = (idx_ff == (cur_ff.count - 2'd1));
   assign take = valid_ff && rsp_pop;
   assign load = !valid_ff || (take && last);
   assign q_pop = load && !q_empty;

   // Next bundle or next event of the current one
   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         cur_in   = head;
         valid_in = !q_empty;
         idx_in   = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Result item from the held bundle
   assign evt              = cur_ff.evts[idx_ff];
   assign rsp.event_res    = evt.code;
   assign rsp.char_out     = evt.char_val;
   assign rsp.byte_offset  = cur_ff.offset;
   assign rsp.end_status   = evt.status;
   assign rsp.final_result = last;
   assign rsp_empty        = !valid_ff;

endmodule

`default_nettype wire
